// File: hw/rtl/bfra_pkg.sv
// shared constants, field widths and codes for the free-run block allocator
package bfra_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int MAX_RUN_DEF    = 256;

  // map words: 16 blocks per word
  localparam int WORD_BITS  = 16;
  localparam int WORD_IDX_W = 4;

  localparam int TOTAL_W    = 11;
  localparam int FIRST_W    = 10;
  localparam int RUN_W      = 9;
  localparam int INDEX_W    = 10;
  localparam int START_W    = 10;
  localparam int COUNT_W    = 9;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;
  localparam logic [FIRST_W-1:0] FIRST_RESET = 10'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_DATA   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_PARTIAL   = 2'd1,
    STATUS_NONE      = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_t;

endpackage

// File: hw/rtl/bfra_map.sv
// used-map word memory with clearing sweep after reset
module bfra_map #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [bfra_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [bfra_pkg::WORD_BITS-1:0] wr_data,
  output logic                           clearing
);

  logic [bfra_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]              clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/bfra_scan.sv
// bit-serial first-fit run search over the used map, else the longest free run seen
module bfra_scan #(
  parameter int BLK_W  = 11,
  parameter int ADDR_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [BLK_W-1:0]               first,
  input  logic [BLK_W-1:0]               size,
  input  logic [bfra_pkg::RUN_W-1:0]     want,
  output logic                           rd_en,
  output logic [ADDR_W-1:0]              rd_addr,
  input  logic [bfra_pkg::WORD_BITS-1:0] rd_data,
  output logic                           done,
  output logic [bfra_pkg::RUN_W-1:0]     best,
  output logic [BLK_W-1:0]               best_start
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_LOAD  = 4'b0100,
    S_RUN   = 4'b1000
  } scan_state_t;

  scan_state_t                    state;
  logic [BLK_W-1:0]               pos;
  logic [BLK_W-1:0]               b;
  logic [bfra_pkg::RUN_W-1:0]     len;
  logic [bfra_pkg::RUN_W-1:0]     want_r;
  logic [bfra_pkg::WORD_BITS-1:0] shreg;
  logic                           cand_ok;
  logic                           used;
  logic                           last_bit;

  always_comb begin
    rd_en    = (state == S_FETCH);
    rd_addr  = ADDR_W'(b >> bfra_pkg::WORD_IDX_W);
    cand_ok  = ({1'b0, pos} + (BLK_W + 1)'(1)) < {1'b0, size};
    used     = (b >= size) || shreg[0];
    last_bit = &b[bfra_pkg::WORD_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            pos        <= first;
            b          <= first;
            len        <= '0;
            best       <= '0;
            best_start <= '0;
            want_r     <= want;
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          shreg <= rd_data >> b[bfra_pkg::WORD_IDX_W-1:0];
          state <= S_RUN;
        end
        S_RUN: begin
          if (len == '0 && !cand_ok) begin
            // no room left for a new candidate
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (!used && (len + 1'b1) == want_r) begin
            best       <= want_r;
            best_start <= pos;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            if (!used) begin
              len <= len + 1'b1;
            end else begin
              if (len > best) begin
                best       <= len;
                best_start <= pos;
              end
              pos <= b + 1'b1;
              len <= '0;
            end
            b     <= b + 1'b1;
            shreg <= shreg >> 1;
            if (last_bit) begin
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/bfra_mark.sv
// word read-modify-write unit that sets or clears a range of used bits
module bfra_mark #(
  parameter int BLK_W  = 11,
  parameter int ADDR_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [BLK_W-1:0]               lo,
  input  logic [bfra_pkg::RUN_W-1:0]     len,
  input  logic                           set_val,
  output logic                           rd_en,
  output logic [ADDR_W-1:0]              rd_addr,
  input  logic [bfra_pkg::WORD_BITS-1:0] rd_data,
  output logic                           wr_en,
  output logic [ADDR_W-1:0]              wr_addr,
  output logic [bfra_pkg::WORD_BITS-1:0] wr_data,
  output logic                           done
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_READ  = 3'b010,
    M_WRITE = 3'b100
  } mark_state_t;

  mark_state_t        state;
  logic [BLK_W:0]     lo_r;
  logic [BLK_W:0]     hi_r;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  last_addr;
  logic               val_r;
  logic [BLK_W:0]     hi_next;

  always_comb begin
    hi_next = (BLK_W + 1)'(lo) + (BLK_W + 1)'(len);
    rd_en   = (state == M_READ);
    rd_addr = waddr;
    wr_en   = (state == M_WRITE);
    wr_addr = waddr;
    for (int i = 0; i < bfra_pkg::WORD_BITS; i++) begin
      if (32'({waddr, bfra_pkg::WORD_IDX_W'(i)}) >= 32'(lo_r) &&
          32'({waddr, bfra_pkg::WORD_IDX_W'(i)}) < 32'(hi_r)) begin
        wr_data[i] = val_r;
      end else begin
        wr_data[i] = rd_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (go) begin
            lo_r      <= {1'b0, lo};
            hi_r      <= hi_next;
            waddr     <= ADDR_W'(lo >> bfra_pkg::WORD_IDX_W);
            last_addr <= ADDR_W'((hi_next - 1'b1) >> bfra_pkg::WORD_IDX_W);
            val_r     <= set_val;
            state     <= M_READ;
          end
        end
        M_READ: begin
          state <= M_WRITE;
        end
        M_WRITE: begin
          if (waddr == last_addr) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            waddr <= waddr + 1'b1;
            state <= M_READ;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/bitmap_free_run_allocator_top.sv
// top level: contiguous first-fit block allocator over a one-bit-per-block used map
// allocate: launch, a scan of one block a cycle paused for a word fetch (FETCH, LOAD)
//   per word, hand-off to the marker, one read-modify-write per map word marked
// free: one word read-modify-write; bad index, empty, no-room requests: answered from idle
// one item at a time: busy high until a scan or mark result strobe; done lasts one cycle
// reset: map cleared by a sweep over every map word, busy high meanwhile
module bitmap_free_run_allocator_top #(
  parameter int NUM_BLOCKS = bfra_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_RUN    = bfra_pkg::MAX_RUN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [bfra_pkg::RUN_W-1:0]        run_length,
  input  logic [bfra_pkg::INDEX_W-1:0]      block_index,
  // result strobe
  output logic                              done,
  output logic [bfra_pkg::START_W-1:0]      start_block,
  output logic [bfra_pkg::COUNT_W-1:0]      granted_count,
  output logic [bfra_pkg::STATUS_W-1:0]     status,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [bfra_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [bfra_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // map geometry; positions must reach one past the volume end
  localparam int DEPTH    = (NUM_BLOCKS + bfra_pkg::WORD_BITS - 1) / bfra_pkg::WORD_BITS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BLK_W    = $clog2(NUM_BLOCKS + 2);
  localparam int MAX_CLIP = (MAX_RUN < 511) ? MAX_RUN : 511;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MARK = 3'b100
  } top_state_t;

  top_state_t state;

  // configuration registers
  logic [bfra_pkg::TOTAL_W-1:0] vol_total;
  logic [bfra_pkg::FIRST_W-1:0] first_data_block;

  // request decode
  logic                       accept;
  logic                       clearing;
  logic [BLK_W-1:0]           size;
  logic [bfra_pkg::RUN_W-1:0] want_sat;
  logic                       start_ok;
  logic                       idx_ok;

  // scanner side
  logic                           scan_go;
  logic [BLK_W-1:0]               scan_first;
  logic [bfra_pkg::RUN_W-1:0]     scan_want;
  logic                           scan_rd_en;
  logic [ADDR_W-1:0]              scan_rd_addr;
  logic                           scan_done;
  logic [bfra_pkg::RUN_W-1:0]     scan_best;
  logic [BLK_W-1:0]               scan_best_start;

  // marker side
  logic                           mark_go;
  logic [BLK_W-1:0]               mark_lo;
  logic [bfra_pkg::RUN_W-1:0]     mark_len;
  logic                           mark_val;
  logic                           mark_rd_en;
  logic [ADDR_W-1:0]              mark_rd_addr;
  logic                           mark_wr_en;
  logic [ADDR_W-1:0]              mark_wr_addr;
  logic [bfra_pkg::WORD_BITS-1:0] mark_wr_data;
  logic                           mark_done;

  // shared map read port
  logic                           map_rd_en;
  logic [ADDR_W-1:0]              map_rd_addr;
  logic [bfra_pkg::WORD_BITS-1:0] map_rd_data;

  // result held while the marker runs
  logic [bfra_pkg::START_W-1:0] hold_start;
  logic [bfra_pkg::COUNT_W-1:0] hold_count;
  bfra_pkg::status_t            hold_status;

  always_comb begin
    busy   = (state != ST_IDLE) || clearing;
    accept = start && !busy;

    // effective volume size is capped at NUM_BLOCKS
    if (32'(vol_total) < 32'(NUM_BLOCKS)) begin
      size = BLK_W'(vol_total);
    end else begin
      size = BLK_W'(NUM_BLOCKS);
    end

    if (run_length > bfra_pkg::RUN_W'(MAX_CLIP)) begin
      want_sat = bfra_pkg::RUN_W'(MAX_CLIP);
    end else begin
      want_sat = run_length;
    end

    // search start must leave at least one block after it
    start_ok = (32'(first_data_block) + 32'd1) < 32'(size);
    idx_ok   = 32'(block_index) < 32'(size);

    map_rd_en   = scan_rd_en || mark_rd_en;
    map_rd_addr = (state == ST_SCAN) ? scan_rd_addr : mark_rd_addr;
  end

  // configuration decode
  always_ff @(posedge clk) begin
    if (rst) begin
      vol_total        <= bfra_pkg::TOTAL_RESET;
      first_data_block <= bfra_pkg::FIRST_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bfra_pkg::CFG_TOTAL_BLOCKS: vol_total        <= cfg_data;
        bfra_pkg::CFG_FIRST_DATA:   first_data_block <= bfra_pkg::FIRST_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      scan_go <= 1'b0;
      mark_go <= 1'b0;
    end else begin
      done    <= 1'b0;
      scan_go <= 1'b0;
      mark_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == bfra_pkg::OP_FREE) begin
              if (idx_ok) begin
                // free is a one-block range clear
                mark_go     <= 1'b1;
                mark_lo     <= BLK_W'(block_index);
                mark_len    <= bfra_pkg::RUN_W'(1);
                mark_val    <= 1'b0;
                hold_start  <= '0;
                hold_count  <= '0;
                hold_status <= bfra_pkg::STATUS_OK;
                state       <= ST_MARK;
              end else begin
                done          <= 1'b1;
                start_block   <= '0;
                granted_count <= '0;
                status        <= bfra_pkg::STATUS_BAD_INDEX;
              end
            end else if (want_sat == '0) begin
              // empty request grants nothing
              done          <= 1'b1;
              start_block   <= '0;
              granted_count <= '0;
              status        <= bfra_pkg::STATUS_OK;
            end else if (!start_ok) begin
              done          <= 1'b1;
              start_block   <= '0;
              granted_count <= '0;
              status        <= bfra_pkg::STATUS_NONE;
            end else begin
              scan_go    <= 1'b1;
              scan_first <= BLK_W'(first_data_block);
              scan_want  <= want_sat;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (scan_best == '0) begin
              done          <= 1'b1;
              start_block   <= '0;
              granted_count <= '0;
              status        <= bfra_pkg::STATUS_NONE;
              state         <= ST_IDLE;
            end else begin
              mark_go     <= 1'b1;
              mark_lo     <= scan_best_start;
              mark_len    <= scan_best;
              mark_val    <= 1'b1;
              hold_start  <= bfra_pkg::START_W'(scan_best_start);
              hold_count  <= scan_best;
              hold_status <= (scan_best == scan_want) ? bfra_pkg::STATUS_OK
                                                      : bfra_pkg::STATUS_PARTIAL;
              state       <= ST_MARK;
            end
          end
        end
        ST_MARK: begin
          if (mark_done) begin
            done          <= 1'b1;
            start_block   <= hold_start;
            granted_count <= hold_count;
            status        <= hold_status;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bfra_map #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (map_rd_en),
    .rd_addr  (map_rd_addr),
    .rd_data  (map_rd_data),
    .wr_en    (mark_wr_en),
    .wr_addr  (mark_wr_addr),
    .wr_data  (mark_wr_data),
    .clearing (clearing)
  );

  bfra_scan #(
    .BLK_W  (BLK_W),
    .ADDR_W (ADDR_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .go         (scan_go),
    .first      (scan_first),
    .size       (size),
    .want       (scan_want),
    .rd_en      (scan_rd_en),
    .rd_addr    (scan_rd_addr),
    .rd_data    (map_rd_data),
    .done       (scan_done),
    .best       (scan_best),
    .best_start (scan_best_start)
  );

  bfra_mark #(
    .BLK_W  (BLK_W),
    .ADDR_W (ADDR_W)
  ) u_mark (
    .clk     (clk),
    .rst     (rst),
    .go      (mark_go),
    .lo      (mark_lo),
    .len     (mark_len),
    .set_val (mark_val),
    .rd_en   (mark_rd_en),
    .rd_addr (mark_rd_addr),
    .rd_data (map_rd_data),
    .wr_en   (mark_wr_en),
    .wr_addr (mark_wr_addr),
    .wr_data (mark_wr_data),
    .done    (mark_done)
  );

endmodule
